/* design/pepc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pepc_pkg
// Shared widths, constants and types of the equal-pair partition cost unit.
// ----------------------------------------------------------------------------
package pepc_pkg;

    // sequence storage
    localparam int MAX_LEN   = 1024;
    localparam int ADDR_W    = 10;              // index into the sequence store
    localparam int LEN_W     = 11;              // 0..MAX_LEN, also row index
    localparam int ROW_DEPTH = MAX_LEN + 1;

    // element values and per-value counts
    localparam int VAL_W     = 10;
    localparam int VAL_RANGE = 1024;
    localparam int CNT_W     = 11;

    // dp row entries, all ones marks an unreachable entry
    localparam int ROW_W     = 20;
    localparam logic [ROW_W-1:0] ROW_INF = {ROW_W{1'b1}};

    // segment count register
    localparam int SEG_W     = 5;
    localparam int MAX_SEG   = 20;

    // result cost
    localparam int COST_W    = 19;
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // range stack of the divide-and-conquer walk
    localparam int STK_DEPTH = 16;
    localparam int STK_IDX_W = 4;
    localparam int STK_PTR_W = 5;

    // one result transaction from the core to the output register
    typedef struct packed {
        logic [COST_W-1:0] min_cost;
        logic              infeasible;
    } pepc_result_t;

endpackage

/* design/partition_equal_pair_cost_dp_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partition_equal_pair_cost_dp_unit
// Least equal-pair cost of a split of a sequence into contiguous segments.
// ----------------------------------------------------------------------------
// Elements stream in one per transaction (one
// read-modify-write of the per-value count table). A transaction with last
// set ends the sequence; the unit then zeroes the count table, runs
// segments-1 dp layers (none when infeasible) and zeroes the table again
// before taking the next element. Each layer fills its row over a
// divide-and-conquer walk of ranges, stepping a sliding window and trying
// each candidate split; window steps share the count table's ports. After
// reset the table is zeroed before the first element is taken.
// One result transaction follows each last element; infeasible is set, with
// cost 0, when segments exceed the length.
module partition_equal_pair_cost_dp_unit
    import pepc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wen,
    input  logic [SEG_W-1:0]   cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [VAL_W-1:0]   s_element,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COST_W-1:0]  m_min_cost,
    output logic               m_infeasible
);

    logic [SEG_W-1:0] seg_reg;
    logic [SEG_W-1:0] seg_k;
    logic             m_valid_reg;
    pepc_result_t     out_reg;
    logic             res_valid;
    logic             res_ready;
    pepc_result_t     res;

    // segment register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg <= SEG_W'(1);
        end else if (cfg_wen) begin
            seg_reg <= cfg_wdata;
        end
    end

    // zero means one, large values clamp to the maximum
    always_comb begin
        if (seg_reg == '0) begin
            seg_k = SEG_W'(1);
        end else if (seg_reg > SEG_W'(MAX_SEG)) begin
            seg_k = SEG_W'(MAX_SEG);
        end else begin
            seg_k = seg_reg;
        end
    end

    pepc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_element (s_element),
        .in_last    (s_last),
        .seg_k      (seg_k),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // output register for the result transaction
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_min_cost   = out_reg.min_cost;
    assign m_infeasible = out_reg.infeasible;

endmodule

/* design/pepc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pepc_core
// Sequencer with memories: loads the sequence, then runs the layered
// partition dp with divide-and-conquer optimization over a sliding window.
// ----------------------------------------------------------------------------
module pepc_core
    import pepc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VAL_W-1:0]   in_element,
    input  logic               in_last,
    input  logic [SEG_W-1:0]   seg_k,
    output logic               res_valid,
    input  logic               res_ready,
    output pepc_result_t       res
);

    typedef enum logic [15:0] {
        ST_CLEAR     = 16'h0001,
        ST_IDLE      = 16'h0002,
        ST_LOAD      = 16'h0004,
        ST_INIT_RD   = 16'h0008,
        ST_INIT_WR   = 16'h0010,
        ST_LAYER     = 16'h0020,
        ST_POP       = 16'h0040,
        ST_CAND      = 16'h0080,
        ST_WIN_PICK  = 16'h0100,
        ST_WIN_CNT   = 16'h0200,
        ST_WIN_UPD   = 16'h0400,
        ST_EVAL_RD   = 16'h0800,
        ST_EVAL_CMP  = 16'h1000,
        ST_RANGE_END = 16'h2000,
        ST_FINAL_RD  = 16'h4000,
        ST_RESULT    = 16'h8000
    } state_t;

    typedef struct packed {
        logic [LEN_W-1:0] lf;
        logic [LEN_W-1:0] rg;
        logic [LEN_W-1:0] lo;
        logic [LEN_W-1:0] hi;
    } range_t;

    // memories
    logic [VAL_W-1:0] seq_mem   [MAX_LEN];
    logic [CNT_W-1:0] cnt_mem   [VAL_RANGE];
    logic [ROW_W-1:0] row_a_mem [ROW_DEPTH];
    logic [ROW_W-1:0] row_b_mem [ROW_DEPTH];

    logic [VAL_W-1:0] seq_rdata_reg;
    logic [CNT_W-1:0] cnt_rdata_reg;
    logic [ROW_W-1:0] row_a_rdata_reg;
    logic [ROW_W-1:0] row_b_rdata_reg;

    // control and datapath registers
    state_t           state_reg;
    logic             clr_to_dp_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [LEN_W-1:0] len_reg;
    logic [ROW_W-1:0] prefix_reg;
    logic [VAL_W-1:0] elem_reg;
    logic             last_reg;
    logic             infeas_reg;
    logic             sel_reg;
    logic [SEG_W-1:0] layer_reg;
    logic [LEN_W-1:0] wl_reg;
    logic [LEN_W-1:0] wr_reg;
    logic [ROW_W-1:0] wcost_reg;
    logic             op_add_reg;
    logic [VAL_W-1:0] val_reg;
    range_t           cur_reg;
    logic [LEN_W-1:0] mid_reg;
    logic [LEN_W-1:0] i_reg;
    logic [LEN_W-1:0] best_reg;
    logic [ROW_W-1:0] best_val_reg;
    range_t           stack_reg [STK_DEPTH];
    logic [STK_PTR_W-1:0] top_reg;

    // memory port controls
    logic [ADDR_W-1:0] seq_raddr;
    logic              seq_we;
    logic [VAL_W-1:0]  cnt_raddr;
    logic              cnt_we;
    logic [VAL_W-1:0]  cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [LEN_W-1:0]  row_raddr;
    logic              row_we;
    logic              row_wbank;
    logic [LEN_W-1:0]  row_waddr;
    logic [ROW_W-1:0]  row_wdata;
    logic [ROW_W-1:0]  row_rdata;

    // window step selection
    logic [LEN_W-1:0]  win_l;
    logic [LEN_W-1:0]  win_p;
    logic              win_done;
    logic              win_add;

    logic              accept;
    logic              len_full;
    logic [ROW_W:0]    cand;
    range_t            pop_e;
    logic [STK_PTR_W-1:0] top_m1;
    logic              push_a;
    logic              push_b;
    logic [STK_PTR_W-1:0] idx_b;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign len_full  = (len_reg == LEN_W'(MAX_LEN));
    assign row_rdata = sel_reg ? row_b_rdata_reg : row_a_rdata_reg;
    assign cand      = {1'b0, row_rdata} + {1'b0, wcost_reg};
    assign top_m1    = top_reg - 1'b1;
    assign pop_e     = stack_reg[top_m1[STK_IDX_W-1:0]];
    assign res_valid = (state_reg == ST_RESULT) && res_ready;

    // result payload, saturated cost
    always_comb begin
        if (infeas_reg) begin
            res.min_cost   = '0;
            res.infeasible = 1'b1;
        end else begin
            res.min_cost   = (row_rdata > ROW_W'(COST_MAX)) ? COST_MAX
                                                            : row_rdata[COST_W-1:0];
            res.infeasible = 1'b0;
        end
    end

    // next window move toward [i+1, mid]
    always_comb begin
        win_l    = i_reg + 1'b1;
        win_done = 1'b0;
        win_add  = 1'b1;
        win_p    = wl_reg;
        if (wl_reg > win_l) begin
            win_p = wl_reg - 1'b1;
        end else if (wr_reg < mid_reg) begin
            win_p = wr_reg + 1'b1;
        end else if (wl_reg < win_l) begin
            win_p   = wl_reg;
            win_add = 1'b0;
        end else if (wr_reg > mid_reg) begin
            win_p   = wr_reg;
            win_add = 1'b0;
        end else begin
            win_done = 1'b1;
        end
    end

    // stack push decisions at the end of a range
    always_comb begin
        push_a = (cur_reg.hi != cur_reg.lo) && (top_reg < STK_PTR_W'(STK_DEPTH));
        idx_b  = push_a ? top_reg + 1'b1 : top_reg;
        push_b = (cur_reg.hi != cur_reg.lo) && (mid_reg > cur_reg.lo)
                 && (idx_b < STK_PTR_W'(STK_DEPTH));
    end

    // memory port selection by state
    always_comb begin
        seq_raddr = '0;
        seq_we    = 1'b0;
        cnt_raddr = seq_rdata_reg;
        cnt_we    = 1'b0;
        cnt_waddr = elem_reg;
        cnt_wdata = '0;
        row_raddr = len_reg;
        row_we    = 1'b0;
        row_wbank = sel_reg;
        row_waddr = '0;
        row_wdata = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_addr_reg;
            end
            ST_IDLE: begin
                cnt_raddr = in_element;
                seq_we    = accept && !len_full;
                row_we    = accept && (len_reg == '0);
            end
            ST_LOAD: begin
                cnt_we    = !len_full;
                cnt_wdata = cnt_rdata_reg + 1'b1;
                row_we    = !len_full;
                row_waddr = len_reg + 1'b1;
                row_wdata = prefix_reg + ROW_W'(cnt_rdata_reg);
            end
            ST_INIT_WR: begin
                cnt_we    = 1'b1;
                cnt_waddr = seq_rdata_reg;
                cnt_wdata = CNT_W'(1);
            end
            ST_LAYER: begin
                row_we    = 1'b1;
                row_wbank = !sel_reg;
                row_wdata = ROW_INF;
            end
            ST_WIN_PICK: begin
                seq_raddr = ADDR_W'(win_p - 1'b1);
            end
            ST_WIN_UPD: begin
                cnt_we    = 1'b1;
                cnt_waddr = val_reg;
                cnt_wdata = op_add_reg ? cnt_rdata_reg + 1'b1 : cnt_rdata_reg - 1'b1;
            end
            ST_EVAL_RD: begin
                row_raddr = i_reg;
            end
            ST_RANGE_END: begin
                row_we    = 1'b1;
                row_wbank = !sel_reg;
                row_waddr = mid_reg;
                row_wdata = best_val_reg;
            end
            ST_INIT_RD, ST_POP, ST_CAND, ST_WIN_CNT, ST_EVAL_CMP,
            ST_FINAL_RD, ST_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    // sequence store
    always_ff @(posedge aclk) begin
        if (seq_we) begin
            seq_mem[len_reg[ADDR_W-1:0]] <= in_element;
        end
        seq_rdata_reg <= seq_mem[seq_raddr];
    end

    // per-value count table
    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata_reg <= cnt_mem[cnt_raddr];
    end

    // two dp rows, roles swap after each layer
    always_ff @(posedge aclk) begin
        if (row_we && !row_wbank) begin
            row_a_mem[row_waddr] <= row_wdata;
        end
        if (row_we && row_wbank) begin
            row_b_mem[row_waddr] <= row_wdata;
        end
        row_a_rdata_reg <= row_a_mem[row_raddr];
        row_b_rdata_reg <= row_b_mem[row_raddr];
    end

    // payload registers without reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            elem_reg <= in_element;
            last_reg <= in_last;
        end
        if (state_reg == ST_WIN_CNT) begin
            val_reg <= seq_rdata_reg;
        end
        if (state_reg == ST_WIN_PICK) begin
            op_add_reg <= win_add;
        end
        if (state_reg == ST_LAYER) begin
            stack_reg[0] <= '{lf: LEN_W'(1), rg: len_reg, lo: LEN_W'(1), hi: len_reg};
        end
        if (state_reg == ST_RANGE_END) begin
            if (push_a) begin
                stack_reg[top_reg[STK_IDX_W-1:0]] <=
                    '{lf: best_reg, rg: cur_reg.rg, lo: mid_reg + 1'b1, hi: cur_reg.hi};
            end
            if (push_b) begin
                stack_reg[idx_b[STK_IDX_W-1:0]] <=
                    '{lf: cur_reg.lf, rg: best_reg, lo: cur_reg.lo, hi: mid_reg - 1'b1};
            end
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_to_dp_reg <= 1'b0;
            clr_addr_reg  <= '0;
            len_reg       <= '0;
            prefix_reg    <= '0;
            infeas_reg    <= 1'b0;
            sel_reg       <= 1'b0;
            layer_reg     <= '0;
            wl_reg        <= '0;
            wr_reg        <= '0;
            wcost_reg     <= '0;
            top_reg       <= '0;
        end else begin
            unique case (state_reg)
                // zero the count table, one entry a cycle
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == ADDR_W'(VAL_RANGE - 1)) begin
                        if (!clr_to_dp_reg) begin
                            state_reg <= ST_IDLE;
                        end else if (infeas_reg) begin
                            state_reg <= ST_RESULT;
                        end else begin
                            state_reg <= ST_INIT_RD;
                        end
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        if (len_reg == '0) begin
                            prefix_reg <= '0;
                        end
                        state_reg <= ST_LOAD;
                    end
                end
                // count lookup returned: extend prefix pair count
                ST_LOAD: begin
                    if (!len_full) begin
                        prefix_reg <= prefix_reg + ROW_W'(cnt_rdata_reg);
                        len_reg    <= len_reg + 1'b1;
                    end
                    if (last_reg) begin
                        clr_to_dp_reg <= 1'b1;
                        infeas_reg    <= (LEN_W'(seg_k) > (len_full ? len_reg
                                                                    : len_reg + 1'b1));
                        state_reg     <= ST_CLEAR;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_INIT_RD: begin
                    state_reg <= ST_INIT_WR;
                end
                // window holds the first element
                ST_INIT_WR: begin
                    wl_reg    <= LEN_W'(1);
                    wr_reg    <= LEN_W'(1);
                    wcost_reg <= '0;
                    layer_reg <= SEG_W'(2);
                    state_reg <= (seg_k == SEG_W'(1)) ? ST_FINAL_RD : ST_LAYER;
                end
                ST_LAYER: begin
                    top_reg   <= STK_PTR_W'(1);
                    state_reg <= ST_POP;
                end
                // take the next range, or finish the layer
                ST_POP: begin
                    if (top_reg == '0) begin
                        sel_reg <= !sel_reg;
                        if (layer_reg == seg_k) begin
                            state_reg <= ST_FINAL_RD;
                        end else begin
                            layer_reg <= layer_reg + 1'b1;
                            state_reg <= ST_LAYER;
                        end
                    end else begin
                        top_reg      <= top_m1;
                        cur_reg      <= pop_e;
                        mid_reg      <= pop_e.lo + ((pop_e.hi - pop_e.lo) >> 1);
                        i_reg        <= pop_e.lf;
                        best_reg     <= pop_e.lf;
                        best_val_reg <= ROW_INF;
                        state_reg    <= ST_CAND;
                    end
                end
                ST_CAND: begin
                    if (i_reg <= cur_reg.rg && i_reg < mid_reg) begin
                        state_reg <= ST_WIN_PICK;
                    end else begin
                        state_reg <= ST_RANGE_END;
                    end
                end
                ST_WIN_PICK: begin
                    if (win_done) begin
                        state_reg <= ST_EVAL_RD;
                    end else begin
                        if (wl_reg > win_l) begin
                            wl_reg <= wl_reg - 1'b1;
                        end else if (wr_reg < mid_reg) begin
                            wr_reg <= wr_reg + 1'b1;
                        end else if (wl_reg < win_l) begin
                            wl_reg <= wl_reg + 1'b1;
                        end else begin
                            wr_reg <= wr_reg - 1'b1;
                        end
                        state_reg <= ST_WIN_CNT;
                    end
                end
                ST_WIN_CNT: begin
                    state_reg <= ST_WIN_UPD;
                end
                // running pair cost follows the count change
                ST_WIN_UPD: begin
                    if (op_add_reg) begin
                        wcost_reg <= wcost_reg + ROW_W'(cnt_rdata_reg);
                    end else begin
                        wcost_reg <= wcost_reg - ROW_W'(cnt_rdata_reg - 1'b1);
                    end
                    state_reg <= ST_WIN_PICK;
                end
                ST_EVAL_RD: begin
                    state_reg <= ST_EVAL_CMP;
                end
                ST_EVAL_CMP: begin
                    if (row_rdata != ROW_INF && cand < {1'b0, best_val_reg}) begin
                        best_val_reg <= cand[ROW_W-1:0];
                        best_reg     <= i_reg;
                    end
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= ST_CAND;
                end
                ST_RANGE_END: begin
                    top_reg   <= top_reg + STK_PTR_W'(push_a) + STK_PTR_W'(push_b);
                    state_reg <= ST_POP;
                end
                ST_FINAL_RD: begin
                    state_reg <= ST_RESULT;
                end
                // hand the result over, then start afresh
                ST_RESULT: begin
                    if (res_ready) begin
                        clr_to_dp_reg <= 1'b0;
                        len_reg       <= '0;
                        prefix_reg    <= '0;
                        wl_reg        <= '0;
                        wr_reg        <= '0;
                        wcost_reg     <= '0;
                        top_reg       <= '0;
                        state_reg     <= ST_CLEAR;
                    end
                end
                default: begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the equal-pair partition cost unit: directed table
// rows, an overlong sequence, then random sequences under several segment
// settings. Answers: table values or a local divide-and-conquer dp.
// ----------------------------------------------------------------------------
module tb;
    import pepc_pkg::*;

    localparam longint UNREACH    = 64'sd1 <<< 62;
    localparam int     IDLE_WAIT  = 2200;
    localparam int     CYCLE_CAP  = 6000000;
    localparam int     RANDOM_NUM = 650;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              inf;
    } answer_t;

    typedef struct {
        int          seg;
        logic [9:0]  elem;
        logic        last;
        bit          typed;
        int          cost;
        bit          inf;
    } stim_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wen = 1'b0;
    logic [SEG_W-1:0]  cfg_wdata = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [VAL_W-1:0]  s_element = '0;
    logic              s_last = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [COST_W-1:0] m_min_cost;
    logic              m_infeasible;

    partition_equal_pair_cost_dp_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_element(s_element), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_min_cost(m_min_cost), .m_infeasible(m_infeasible)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [VAL_W-1:0] seq_buf [0:MAX_LEN-1];
    int               seq_len = 0;
    int               seg_reg = 1;
    longint           prev_row [0:MAX_LEN];
    longint           cur_row [0:MAX_LEN];
    int               val_cnt [0:VAL_RANGE-1];
    int               win_lo, win_hi;
    longint           win_cost;
    int               rng_stk [0:39][0:3];
    int               stk_ptr;

    answer_t          pending_answers [$];
    int               err_cnt = 0;
    int               cycle_cnt = 0;
    int               stall_left = 0;
    bit               typed_next = 0;
    answer_t          typed_answer;

    task automatic report_err(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    function automatic int val_at(input int p);
        int idx;
        idx = (p >= 1) ? p - 1 : 0;
        if (idx >= MAX_LEN) idx = MAX_LEN - 1;
        return seq_buf[idx];
    endfunction

    function automatic void win_add(input int p);
        int v;
        v = val_at(p);
        win_cost += val_cnt[v];
        val_cnt[v]++;
    endfunction

    function automatic void win_del(input int p);
        int v;
        v = val_at(p);
        val_cnt[v]--;
        win_cost -= val_cnt[v];
    endfunction

    // widen first so no count goes negative
    function automatic void slide_window(input int l, input int r);
        while (win_lo > l) begin win_lo--; win_add(win_lo); end
        while (win_hi < r) begin win_hi++; win_add(win_hi); end
        while (win_lo < l) begin win_del(win_lo); win_lo++; end
        while (win_hi > r) begin win_del(win_hi); win_hi--; end
    endfunction

    function automatic void push_rng(input int lf, input int rg, input int lo, input int hi);
        if (hi < lo || stk_ptr >= 40) return;
        rng_stk[stk_ptr][0] = lf;
        rng_stk[stk_ptr][1] = rg;
        rng_stk[stk_ptr][2] = lo;
        rng_stk[stk_ptr][3] = hi;
        stk_ptr++;
    endfunction

    // one dp layer, divide and conquer over split points
    function automatic void dp_layer(input int n);
        int lf, rg, lo, hi, mid, best;
        longint cand;
        for (int j = 0; j <= n; j++) cur_row[j] = UNREACH;
        stk_ptr = 0;
        push_rng(1, n, 1, n);
        while (stk_ptr > 0) begin
            stk_ptr--;
            lf = rng_stk[stk_ptr][0];
            rg = rng_stk[stk_ptr][1];
            lo = rng_stk[stk_ptr][2];
            hi = rng_stk[stk_ptr][3];
            mid = lo + (hi - lo) / 2;
            best = lf;
            for (int i = lf; i <= rg && i < mid; i++) begin
                slide_window(i + 1, mid);
                if (prev_row[i] != UNREACH) begin
                    cand = prev_row[i] + win_cost;
                    if (cand < cur_row[mid]) begin
                        best = i;
                        cur_row[mid] = cand;
                    end
                end
            end
            if (hi != lo) begin
                push_rng(best, rg, mid + 1, hi);
                if (mid > lo) push_rng(lf, best, lo, mid - 1);
            end
        end
        for (int j = 0; j <= n; j++) prev_row[j] = cur_row[j];
    endfunction

    function automatic answer_t split_cost(input int n, input int k_raw);
        answer_t a;
        int k, v;
        longint c;
        k = (k_raw == 0) ? 1 : k_raw;
        if (k > MAX_SEG) k = MAX_SEG;
        // single-segment row: prefix pair counts
        for (int i = 0; i < VAL_RANGE; i++) val_cnt[i] = 0;
        prev_row[0] = 0;
        for (int j = 1; j <= n; j++) begin
            v = val_at(j);
            prev_row[j] = prev_row[j-1] + val_cnt[v];
            val_cnt[v]++;
        end
        for (int i = 0; i < VAL_RANGE; i++) val_cnt[i] = 0;
        if (k > n) begin
            a.cost = '0;
            a.inf  = 1'b1;
            return a;
        end
        win_lo = 1;
        win_hi = 1;
        win_cost = 0;
        val_cnt[val_at(1)] = 1;
        for (int layer = 2; layer <= k; layer++) dp_layer(n);
        c = prev_row[n];
        if (c > COST_MAX) c = COST_MAX;
        a.cost = c[COST_W-1:0];
        a.inf  = 1'b0;
        return a;
    endfunction

    // record one accepted element
    function automatic void take_element(input logic [9:0] e, input logic l);
        if (seq_len < MAX_LEN) begin
            seq_buf[seq_len] = e;
            seq_len++;
        end
        if (l) begin
            if (typed_next) pending_answers.push_back(typed_answer);
            else pending_answers.push_back(split_cost(seq_len, seg_reg));
            typed_next = 0;
            seq_len = 0;
        end
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_element(input logic [9:0] e, input logic l);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_element <= e;
        s_last    <= l;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        take_element(e, l);
        @(negedge aclk);
    endtask

    // write segments only once the unit has drained
    task automatic set_segments(input int v);
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge aclk);
        repeat (IDLE_WAIT) @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v[SEG_W-1:0];
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        seg_reg = v;
    endtask

    // result side stalls
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 25) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                      : $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result check
    always @(posedge aclk) begin
        answer_t exp_a;
        if (m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                report_err("result with no answer waiting");
            end else begin
                exp_a = pending_answers.pop_front();
                if (m_min_cost !== exp_a.cost)
                    report_err($sformatf("min_cost %0d, expected %0d",
                                         m_min_cost, exp_a.cost));
                if (m_infeasible !== exp_a.inf)
                    report_err($sformatf("infeasible %0b, expected %0b",
                                         m_infeasible, exp_a.inf));
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        stim_row_t rows [$];
        int        sent;
        int        n, alpha, nseq;
        int        seg_plan [$];
        logic [9:0] e;

        // directed sequences
        rows = '{
            '{1, 10'd7, 1'b0, 1'b1, 3, 1'b0},
            '{1, 10'd7, 1'b0, 1'b1, 3, 1'b0},
            '{1, 10'd7, 1'b1, 1'b1, 3, 1'b0},
            '{1, 10'd1023, 1'b1, 1'b1, 0, 1'b0},
            '{1, 10'd0, 1'b0, 1'b1, 2, 1'b0},
            '{1, 10'd1023, 1'b0, 1'b1, 2, 1'b0},
            '{1, 10'd0, 1'b0, 1'b1, 2, 1'b0},
            '{1, 10'd1023, 1'b1, 1'b1, 2, 1'b0},
            // too many segments
            '{3, 10'd4, 1'b0, 1'b1, 0, 1'b1},
            '{3, 10'd4, 1'b1, 1'b1, 0, 1'b1},
            // zero segments acts as one
            '{0, 10'd9, 1'b0, 1'b1, 1, 1'b0},
            '{0, 10'd9, 1'b1, 1'b1, 1, 1'b0},
            '{2, 10'd1, 1'b0, 1'b0, 0, 1'b0},
            '{2, 10'd1, 1'b0, 1'b0, 0, 1'b0},
            '{2, 10'd2, 1'b0, 1'b0, 0, 1'b0},
            '{2, 10'd2, 1'b0, 1'b0, 0, 1'b0},
            '{2, 10'd1, 1'b1, 1'b0, 0, 1'b0},
            // segments above the maximum saturate
            '{31, 10'd3, 1'b1, 1'b1, 0, 1'b1},
            '{20, 10'd512, 1'b1, 1'b1, 0, 1'b1}
        };

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (rows[i]) begin
            if (rows[i].seg != seg_reg && seq_len == 0) set_segments(rows[i].seg);
            if (rows[i].typed && rows[i].last) begin
                typed_next   = 1;
                typed_answer = '{rows[i].cost[COST_W-1:0], rows[i].inf};
            end
            send_element(rows[i].elem, rows[i].last);
        end

        // overlong sequence, tail elements dropped
        set_segments(2);
        for (int i = 0; i < MAX_LEN + 6; i++)
            send_element($urandom_range(0, 63), i == MAX_LEN + 5);

        // random sequences over several segment settings
        seg_plan = '{1, 2, 5, 20, 3, 0, 31, 7, 2, 1};
        sent = 0;
        foreach (seg_plan[p]) begin
            set_segments(seg_plan[p]);
            nseq = $urandom_range(3, 8);
            for (int s = 0; s < nseq && sent < RANDOM_NUM; s++) begin
                if ($urandom_range(0, 9) == 0) n = $urandom_range(40, 120);
                else n = $urandom_range(1, 24);
                alpha = ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(1, 7);
                for (int i = 0; i < n; i++) begin
                    e = $urandom_range(0, alpha);
                    send_element(e, i == n - 1);
                    sent++;
                end
            end
        end

        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(negedge aclk);
        repeat (IDLE_WAIT) @(negedge aclk);
        if (err_cnt == 0 && pending_answers.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/pepc_pkg.sv
design/pepc_core.sv
design/partition_equal_pair_cost_dp_unit.sv
verif/tb.sv
